/* design/rpd_pkg.sv */
// Shared types and constants for the run-length pair decoder.
package rpd_pkg;

   localparam int LANES       = 8;
   localparam int WORD_LANES  = (LANES > 8) ? 8 : LANES;
   localparam int SIZE_W      = 25;
   localparam int COUNT_W     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(65536);
   localparam logic [COUNT_W-1:0] WORD_BYTES = COUNT_W'(WORD_LANES);

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic               out_kind;
      logic [63:0]        out_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               stream_ok;
      logic               run_end;
   } rsp_type;

   // One queued job: expand a run, then optionally report status.
   typedef struct packed {
      logic [7:0] run;
      logic [7:0] value;
      logic       status;
      logic       ok;
   } cmd_type;

endpackage

/* design/rpd_front.sv */
// Front end: parses run/value pairs, checks sizes, queues expansion jobs.
module rpd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rpd_pkg::req_type              req_data,
   input  logic                          csr_wen,
   input  logic [rpd_pkg::SIZE_W-1:0]    csr_wdata,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output rpd_pkg::cmd_type              cmd
);

   logic [rpd_pkg::SIZE_W-1:0] output_size_ff, output_size_in;
   logic                       expect_value_ff, expect_value_in;
   logic [7:0]                 held_run_ff, held_run_in;
   logic [rpd_pkg::SIZE_W-1:0] produced_ff, produced_in;
   logic                       error_ff, error_in;
   logic                       accept;
   logic [rpd_pkg::SIZE_W:0]   sum;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;
   assign sum       = {1'b0, produced_ff} + {(rpd_pkg::SIZE_W - 7)'(0), held_run_ff};

   always_comb begin
      output_size_in  = csr_wen ? csr_wdata : output_size_ff;
      expect_value_in = expect_value_ff;
      held_run_in     = held_run_ff;
      produced_in     = produced_ff;
      error_in        = error_ff;
      cmd.run         = '0;
      cmd.value       = req_data.in_byte;
      cmd.status      = req_data.in_last;
      cmd.ok          = 1'b0;
      if (!expect_value_ff) begin
         held_run_in     = req_data.in_byte;
         expect_value_in = 1'b1;
         if (produced_ff >= output_size_ff || req_data.in_last) begin
            error_in = 1'b1;
         end
      end else begin
         expect_value_in = 1'b0;
         if (!error_ff) begin
            if (sum > {1'b0, output_size_ff}) begin
               error_in = 1'b1;
            end else begin
               cmd.run     = held_run_ff;
               produced_in = sum[rpd_pkg::SIZE_W-1:0];
            end
         end
      end
      cmd.ok    = !error_in && !expect_value_in && (produced_in == output_size_ff);
      cmd_valid = req_valid && (req_data.in_last || (cmd.run != '0));
      if (req_data.in_last) begin
         expect_value_in = 1'b0;
         held_run_in     = '0;
         produced_in     = '0;
         error_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff  <= rpd_pkg::SIZE_RESET;
         expect_value_ff <= 1'b0;
         held_run_ff     <= '0;
         produced_ff     <= '0;
         error_ff        <= 1'b0;
      end else begin
         output_size_ff <= output_size_in;
         if (accept) begin
            expect_value_ff <= expect_value_in;
            held_run_ff     <= held_run_in;
            produced_ff     <= produced_in;
            error_ff        <= error_in;
         end
      end
   end

endmodule

/* design/rpd_queue.sv */
// Small job queue between the front and back ends.
module rpd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rpd_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rpd_pkg::cmd_type pop_data
);

   rpd_pkg::cmd_type            entries_ff [rpd_pkg::QUEUE_DEPTH];
   logic [rpd_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [rpd_pkg::QCNT_W-1:0]  count_ff;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != rpd_pkg::QCNT_W'(rpd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + rpd_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + rpd_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + rpd_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - rpd_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

/* design/rpd_back.sv */
// Back end: expands queued runs into data words and emits status beats.
module rpd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  rpd_pkg::cmd_type job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rpd_pkg::rsp_type rsp_data
);

   logic                           active_ff, active_in;
   logic [7:0]                     rem_ff, rem_in;
   logic [7:0]                     value_ff, value_in;
   logic                           status_ff, status_in;
   logic                           ok_ff, ok_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rpd_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           out_free;
   logic                           emit;
   logic                           done;
   logic [rpd_pkg::COUNT_W-1:0]    take;
   logic [7:0]                     rem_left;
   logic [63:0]                    word;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = active_ff && out_free;
   assign take     = (rem_ff < {(8 - rpd_pkg::COUNT_W)'(0), rpd_pkg::WORD_BYTES})
                     ? rem_ff[rpd_pkg::COUNT_W-1:0] : rpd_pkg::WORD_BYTES;
   assign rem_left = rem_ff - {(8 - rpd_pkg::COUNT_W)'(0), take};
   assign done     = emit && (rem_ff == '0 || (rem_left == '0 && !status_ff));
   assign job_ready = !active_ff || done;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         word[8*i +: 8] = (rpd_pkg::COUNT_W'(i) < take) ? value_ff : 8'h00;
      end
   end

   always_comb begin
      active_in    = active_ff;
      rem_in       = rem_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (rem_ff != '0) begin
            rsp_in.out_kind   = rpd_pkg::KIND_DATA;
            rsp_in.out_bytes  = word;
            rsp_in.byte_count = take;
            rsp_in.stream_ok  = 1'b0;
            rsp_in.run_end    = (rem_left == '0) && !status_ff;
            rem_in            = rem_left;
         end else begin
            rsp_in.out_kind   = rpd_pkg::KIND_STATUS;
            rsp_in.out_bytes  = '0;
            rsp_in.byte_count = '0;
            rsp_in.stream_ok  = ok_ff;
            rsp_in.run_end    = 1'b1;
         end
      end
      if (done) begin
         active_in = 1'b0;
      end
      if (job_valid && job_ready) begin
         active_in = 1'b1;
         rem_in    = job.run;
         value_in  = job.value;
         status_in = job.status;
         ok_in     = job.ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff    <= rem_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      ok_ff     <= ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/rle_pair_decoder.sv */
// Run-length pair decoder top level: front parser, job queue, word expander.
// A taken value byte's job passes the queue, the expander and the output register.
// Throughput: one input byte per cycle while the 4-entry job queue has room;
// the expander emits one beat per cycle when rsp_ready allows, ceil(run/8) data
// beats plus one status beat on a last byte, so long runs set the sustained rate.
// Reset (synchronous): stream state cleared, queue empty, output_size = 65536.
module rle_pair_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rpd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rpd_pkg::rsp_type           rsp_data,
   input  logic                       csr_wen,
   input  logic [rpd_pkg::SIZE_W-1:0] csr_wdata
);

   logic             push_valid, push_ready;
   rpd_pkg::cmd_type push_data;
   logic             job_valid, job_ready;
   rpd_pkg::cmd_type job;

   rpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd       (push_data)
   );

   rpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job)
   );

   rpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/rle_pair_decoder_test.sv */
// Self-checking testbench for rle_pair_decoder: directed and random pair streams vs a predictor.
module rle_pair_decoder_test;

   localparam int QUIET_LIMIT = 1000;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   rpd_pkg::req_type           req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rpd_pkg::rsp_type           rsp_data;
   logic                       csr_wen   = 1'b0;
   logic [rpd_pkg::SIZE_W-1:0] csr_wdata = '0;

   rle_pair_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // stimulus and expected beats
   rpd_pkg::req_type stream_bytes[$];
   rpd_pkg::rsp_type owed_beats[$];
   int               queued_total   = 0;
   int               taken_total    = 0;
   int               mismatch_count = 0;
   logic             calm           = 1'b0;
   logic             req_beat       = 1'b0;
   logic             rsp_beat       = 1'b0;
   int               req_gap        = 0;
   int               rsp_wait       = 0;
   int               quiet_cycles   = 0;

   // predictor state
   logic [rpd_pkg::SIZE_W-1:0] out_size   = rpd_pkg::SIZE_RESET;
   logic                       want_value = 1'b0;
   logic [7:0]                 run_hold   = '0;
   logic [rpd_pkg::SIZE_W-1:0] produced   = '0;
   logic                       stream_bad = 1'b0;

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic decode_byte(input rpd_pkg::req_type item);
      int                       n_before;
      int                       left;
      int                       take;
      int                       i;
      logic [rpd_pkg::SIZE_W:0] total;
      rpd_pkg::rsp_type         beat;
      n_before = owed_beats.size();
      if (!want_value) begin
         if (produced >= out_size) stream_bad = 1'b1;
         run_hold   = item.in_byte;
         want_value = 1'b1;
         if (item.in_last) stream_bad = 1'b1;
      end else begin
         want_value = 1'b0;
         if (!stream_bad) begin
            total = (rpd_pkg::SIZE_W+1)'(produced) + (rpd_pkg::SIZE_W+1)'(run_hold);
            if (total > (rpd_pkg::SIZE_W+1)'(out_size)) begin
               stream_bad = 1'b1;
            end else begin
               left = run_hold;
               while (left > 0) begin
                  take = (left < rpd_pkg::WORD_LANES) ? left : rpd_pkg::WORD_LANES;
                  beat = '0;
                  beat.out_kind = rpd_pkg::KIND_DATA;
                  for (i = 0; i < take; i++) beat.out_bytes[8*i +: 8] = item.in_byte;
                  beat.byte_count = rpd_pkg::COUNT_W'(take);
                  owed_beats.push_back(beat);
                  left -= take;
               end
               produced = total[rpd_pkg::SIZE_W-1:0];
            end
         end
      end
      if (item.in_last) begin
         beat = '0;
         beat.out_kind  = rpd_pkg::KIND_STATUS;
         beat.stream_ok = !stream_bad && !want_value && (produced == out_size);
         owed_beats.push_back(beat);
         want_value = 1'b0;
         run_hold   = '0;
         produced   = '0;
         stream_bad = 1'b0;
      end
      if (owed_beats.size() > n_before) begin
         beat = owed_beats.pop_back();
         beat.run_end = 1'b1;
         owed_beats.push_back(beat);
      end
   endtask

   task automatic check_beat(input rpd_pkg::rsp_type got);
      rpd_pkg::rsp_type want;
      if (owed_beats.size() == 0) begin
         note_mismatch($sformatf("beat with nothing expected, kind %0d", got.out_kind));
      end else begin
         want = owed_beats.pop_front();
         if (got.out_kind !== want.out_kind)
            note_mismatch($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
         if (got.out_bytes !== want.out_bytes)
            note_mismatch($sformatf("out_bytes %h, want %h", got.out_bytes, want.out_bytes));
         if (got.byte_count !== want.byte_count)
            note_mismatch($sformatf("byte_count %0d, want %0d",
                                    got.byte_count, want.byte_count));
         if (got.stream_ok !== want.stream_ok)
            note_mismatch($sformatf("stream_ok %0d, want %0d", got.stream_ok, want.stream_ok));
         if (got.run_end !== want.run_end)
            note_mismatch($sformatf("run_end %0d, want %0d", got.run_end, want.run_end));
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (stream_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= stream_bytes.pop_front();
            req_gap   <= calm ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_beat) rsp_wait = calm ? 0 : $urandom_range(0, 6);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_beat <= 1'b0;
         rsp_beat <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_beat <= req_valid && req_ready;
         rsp_beat <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            taken_total++;
         end
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("FAIL rle_pair_decoder");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
   end

   task automatic push_byte(input logic [7:0] value, input logic last);
      rpd_pkg::req_type item;
      item.in_byte = value;
      item.in_last = last;
      stream_bytes.push_back(item);
      queued_total++;
   endtask

   task automatic push_pair(input logic [7:0] run, input logic [7:0] value, input logic last);
      push_byte(run, 1'b0);
      push_byte(value, last);
   endtask

   // pairs producing exactly amount bytes
   task automatic fill_bytes(input int amount, input logic mark_last);
      int left;
      int run;
      int pick;
      left = amount;
      if (left == 0 && mark_last) push_pair(8'd0, 8'($urandom_range(0, 255)), 1'b1);
      while (left > 0) begin
         run  = (left < 255) ? left : 255;
         pick = $urandom_range(0, 5);
         if (pick == 0) run = 0;
         else if (pick > 1) run = $urandom_range(1, run);
         left -= run;
         push_pair(8'(run), 8'($urandom_range(0, 255)), mark_last && (left == 0));
      end
   endtask

   task automatic queue_stream(input int size);
      int fill;
      int pick;
      int run;
      fill = (size > 400) ? $urandom_range(0, 400) : size;
      pick = $urandom_range(0, 9);
      if (pick == 0 && fill == size && fill < 250) begin
         // run overflows the output
         fill_bytes(fill / 2, 1'b0);
         run = fill - fill / 2 + 1 + $urandom_range(0, 3);
         push_pair(8'(run), 8'($urandom_range(0, 255)), 1'b0);
         push_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 1) begin
         fill_bytes(fill, 1'b0);
         push_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 2) begin
         // odd trailing byte
         fill_bytes(fill, 1'b0);
         push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 3) begin
         repeat ($urandom_range(1, 8))
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         fill_bytes(fill, 1'b1);
      end
   endtask

   task automatic settle();
      while (taken_total != queued_total || owed_beats.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_size(input int size);
      csr_wen   <= 1'b1;
      csr_wdata <= rpd_pkg::SIZE_W'(size);
      out_size = rpd_pkg::SIZE_W'(size);
      @(negedge clock) csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int size;
      int phase;
      int directed_total;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // reset size: zero run, byte extremes, longest run, odd trailing byte
      push_pair(8'd0, 8'h00, 1'b0);
      push_pair(8'd1, 8'hFF, 1'b0);
      push_pair(8'd8, 8'hA5, 1'b0);
      push_pair(8'd9, 8'h5A, 1'b0);
      push_pair(8'd255, 8'h3C, 1'b1);
      push_byte(8'd7, 1'b1);
      settle();
      write_size(20);
      push_pair(8'd8, 8'h11, 1'b0);
      push_pair(8'd12, 8'h22, 1'b1);
      push_pair(8'd15, 8'h33, 1'b0);
      push_pair(8'd6, 8'h44, 1'b1);
      push_pair(8'd20, 8'h55, 1'b0);
      push_pair(8'd1, 8'h66, 1'b1);
      settle();
      write_size(0);
      push_pair(8'd0, 8'h77, 1'b1);
      settle();
      write_size(1);
      push_pair(8'd1, 8'h88, 1'b1);

      directed_total = queued_total;
      phase = 0;
      while (queued_total - directed_total < 90) begin
         settle();
         if (phase == 0) size = 16777216;
         else if (phase == 1) size = 33554431;
         else if ($urandom_range(0, 7) == 0) size = 1;
         else size = $urandom_range(1, 200);
         write_size(size);
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) queue_stream(size);
         phase++;
      end
      settle();
      repeat (20) @(negedge clock);

      if (owed_beats.size() != 0)
         note_mismatch($sformatf("%0d expected beats never arrived", owed_beats.size()));
      if (mismatch_count == 0) begin
         $display("PASS rle_pair_decoder");
      end else begin
         $display("FAIL rle_pair_decoder");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/rpd_pkg.sv
design/rpd_front.sv
design/rpd_queue.sv
design/rpd_back.sv
design/rle_pair_decoder.sv
sim/rle_pair_decoder_test.sv
